FILE: rtl/ogrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy grid rectangle fill - shared definitions
// Field widths, register indexes, action codes, controller states and the
// command/status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package ogrf_pkg;

    // Field widths
    localparam int ACT_W      = 2;
    localparam int COORD_W    = 24;  // signed Q15.8 coordinate
    localparam int SIZE_W     = 23;  // unsigned Q15.8 size
    localparam int QIDX_W     = 6;   // query row / column index
    localparam int USED_W     = 7;   // columns_used / rows_used
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // Corner arithmetic: offset from origin, doubled-scale numerator, divisor
    localparam int DIFF_W    = COORD_W + 1;   // centre minus origin
    localparam int NUM_W     = DIFF_W + 1;    // non-negative doubled numerator
    localparam int DEN_W     = SIZE_W + 1;    // twice the cell size
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    // Default grid size and register reset values
    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    localparam logic [COORD_W-1:0] RST_ORIGIN    = '0;
    localparam logic [SIZE_W-1:0]  RST_CELL_SIZE = SIZE_W'(256);
    localparam logic [USED_W-1:0]  RST_USED      = USED_W'(64);

    // Action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_MARK  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_CELL_WIDTH   = 3'd2,
        REG_CELL_HEIGHT  = 3'd3,
        REG_COLUMNS_USED = 3'd4,
        REG_ROWS_USED    = 3'd5
    } cfg_reg_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SAT,
        ST_MASK,
        ST_FILL,
        ST_QREAD,
        ST_QEVAL,
        ST_CLR,
        ST_DONE
    } ogrf_state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;       // take the input word
        logic row_zero;    // restart the row counter
        logic div_start;   // load the four corner dividers
        logic sat_load;    // clip the quotients
        logic mask_load;   // build the column mask, set first row
        logic fill_read;   // read one row for the OR update
        logic query_read;  // read the queried row
        logic query_eval;  // form blocked / out_of_range
        logic clr_write;   // zero one row
    } ogrf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic mask_empty;
        logic row_active;
        logic clr_last;
    } ogrf_status_t;

endpackage
`default_nettype wire

FILE: rtl/ogrf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Corner index divider
// Restoring divider, one quotient bit per cycle, NUM_W quotient bits per division.
// ----------------------------------------------------------------------------
module ogrf_div
    import ogrf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  running,
    output logic [NUM_W-1:0]      quot
);

    logic [NUM_W-1:0]     quot_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;

    logic [DEN_W:0]       shift_next;
    logic [DEN_W:0]       diff_next;
    logic                 ge_next;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        shift_next = {rem_reg, quot_reg[NUM_W-1]};
        ge_next    = shift_next >= {1'b0, den};
        diff_next  = shift_next - {1'b0, den};
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= DIV_CNT_W'(NUM_W);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
                run_reg <= 1'b0;
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], ge_next};
            rem_reg  <= ge_next ? diff_next[DEN_W-1:0] : shift_next[DEN_W-1:0];
        end
    end

    assign running = run_reg;
    assign quot    = quot_reg;

endmodule
`default_nettype wire

FILE: rtl/ogrf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy grid datapath
// Configuration registers, corner arithmetic with four dividers, column mask,
// row counter and the grid memory (one row word per address).
// ----------------------------------------------------------------------------
module ogrf_datapath
    import ogrf_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [ACT_W-1:0]      action,
    input  wire logic [COORD_W-1:0]    center_x,
    input  wire logic [COORD_W-1:0]    center_y,
    input  wire logic [SIZE_W-1:0]     size_x,
    input  wire logic [SIZE_W-1:0]     size_y,
    input  wire logic [QIDX_W-1:0]     query_row,
    input  wire logic [QIDX_W-1:0]     query_col,
    input  wire ogrf_cmd_t             cmd,
    output ogrf_status_t               status,
    output logic [ACT_W-1:0]           echo_action,
    output logic                       blocked,
    output logic                       out_of_range
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;  // row address
    localparam int RCW = $clog2(MAX_ROWS + 1);                   // row count
    localparam int CCW = $clog2(MAX_COLUMNS + 1);                // column count
    localparam int NRW = (RCW > USED_W) ? RCW : USED_W;
    localparam int QRW = (RCW > QIDX_W) ? RCW : QIDX_W;

    // Configuration registers
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic [SIZE_W-1:0]         cell_width_reg;
    logic [SIZE_W-1:0]         cell_height_reg;
    logic [USED_W-1:0]         columns_used_reg;
    logic [USED_W-1:0]         rows_used_reg;

    // Item registers
    logic [ACT_W-1:0]          action_reg;
    logic signed [DIFF_W-1:0]  dx_reg;
    logic signed [DIFF_W-1:0]  dy_reg;
    logic [SIZE_W-1:0]         sx_reg;
    logic [SIZE_W-1:0]         sy_reg;
    logic [QIDX_W-1:0]         qrow_reg;
    logic [QIDX_W-1:0]         qcol_reg;
    logic                      blocked_reg;
    logic                      oor_reg;

    // Clipped corners, mask and row walk
    logic [CCW-1:0]            lsat_reg;
    logic [CCW-1:0]            rsat_reg;
    logic [RCW-1:0]            usat_reg;
    logic [RCW-1:0]            dsat_reg;
    logic [MAX_COLUMNS-1:0]    mask_reg;
    logic [MAX_COLUMNS-1:0]    mask_next;
    logic [RCW-1:0]            row_reg;
    logic                      wr_pend_reg;
    logic [RW-1:0]             wr_addr_reg;

    // Grid memory
    logic [MAX_COLUMNS-1:0]    occ_mem [MAX_ROWS];
    logic [MAX_COLUMNS-1:0]    rdata_reg;

    // Derived values
    logic [SIZE_W-1:0]         cw_eff;
    logic [SIZE_W-1:0]         ch_eff;
    logic [NUM_W-1:0]          num_l;
    logic [NUM_W-1:0]          num_r;
    logic [NUM_W-1:0]          num_u;
    logic [NUM_W-1:0]          num_d;
    logic [NUM_W-1:0]          q_l;
    logic [NUM_W-1:0]          q_r;
    logic [NUM_W-1:0]          q_u;
    logic [NUM_W-1:0]          q_d;
    logic                      run_l;
    logic                      run_r;
    logic                      run_u;
    logic                      run_d;
    logic [CCW-1:0]            ncol;
    logic [RCW-1:0]            nrow;
    logic [RW-1:0]             qaddr;
    logic                      q_oor;
    logic [MAX_COLUMNS-1:0]    q_word;
    logic                      wr_en;
    logic [RW-1:0]             wr_addr;
    logic [MAX_COLUMNS-1:0]    wr_data;
    logic                      rd_en;
    logic [RW-1:0]             rd_addr;

    // Doubled numerator (2*d -/+ s, or 2*d alone when s is one cell), clamped at zero when negative
    function automatic logic [NUM_W-1:0] corner_num(
        input logic signed [DIFF_W-1:0] d,
        input logic [SIZE_W-1:0]        s,
        input logic                     single,
        input logic                     neg
    );
        logic signed [NUM_W:0] d2;
        logic signed [NUM_W:0] se;
        logic signed [NUM_W:0] v;
        d2 = {d[DIFF_W-1], d, 1'b0};
        se = $signed({{(NUM_W + 1 - SIZE_W){1'b0}}, s});
        if (single)
            v = d2;
        else if (neg)
            v = d2 - se;
        else
            v = d2 + se;
        corner_num = v[NUM_W] ? '0 : v[NUM_W-1:0];
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= RST_ORIGIN;
            origin_y_reg     <= RST_ORIGIN;
            cell_width_reg   <= RST_CELL_SIZE;
            cell_height_reg  <= RST_CELL_SIZE;
            columns_used_reg <= RST_USED;
            rows_used_reg    <= RST_USED;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                REG_CELL_WIDTH:   cell_width_reg   <= cfg_data[SIZE_W-1:0];
                REG_CELL_HEIGHT:  cell_height_reg  <= cfg_data[SIZE_W-1:0];
                REG_COLUMNS_USED: columns_used_reg <= cfg_data[USED_W-1:0];
                REG_ROWS_USED:    rows_used_reg    <= cfg_data[USED_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective cell sizes and area in use
    always_comb
    begin
        cw_eff = (cell_width_reg == '0) ? SIZE_W'(1) : cell_width_reg;
        ch_eff = (cell_height_reg == '0) ? SIZE_W'(1) : cell_height_reg;
        ncol   = (columns_used_reg > USED_W'(MAX_COLUMNS)) ? CCW'(MAX_COLUMNS)
                                                           : CCW'(columns_used_reg);
        nrow   = (NRW'(rows_used_reg) > NRW'(MAX_ROWS)) ? RCW'(MAX_ROWS)
                                                        : RCW'(rows_used_reg);
    end

    // Corner numerators; y already flipped in dy_reg
    always_comb
    begin
        num_l = corner_num(dx_reg, sx_reg, sx_reg == cw_eff, 1'b1);
        num_r = corner_num(dx_reg, sx_reg, sx_reg == cw_eff, 1'b0);
        num_u = corner_num(dy_reg, sy_reg, sy_reg == ch_eff, 1'b1);
        num_d = corner_num(dy_reg, sy_reg, sy_reg == ch_eff, 1'b0);
    end

    // Four corner dividers, run side by side
    ogrf_div u_div_left
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num     (num_l),
        .den     ({cw_eff, 1'b0}),
        .running (run_l),
        .quot    (q_l)
    );

    ogrf_div u_div_right
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num     (num_r),
        .den     ({cw_eff, 1'b0}),
        .running (run_r),
        .quot    (q_r)
    );

    ogrf_div u_div_up
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num     (num_u),
        .den     ({ch_eff, 1'b0}),
        .running (run_u),
        .quot    (q_u)
    );

    ogrf_div u_div_down
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num     (num_d),
        .den     ({ch_eff, 1'b0}),
        .running (run_d),
        .quot    (q_d)
    );

    // Column mask from the clipped left and right columns
    always_comb
    begin
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            mask_next[c] = (CCW'(c) >= lsat_reg) && (CCW'(c) <= rsat_reg)
                           && (CCW'(c) < ncol);
        end
    end

    // Query address and range check
    always_comb
    begin
        qaddr  = (QRW'(qrow_reg) < QRW'(MAX_ROWS)) ? RW'(qrow_reg) : '0;
        q_oor  = (QRW'(qrow_reg) >= QRW'(nrow)) || (USED_W'(qcol_reg) >= USED_W'(ncol));
        q_word = rdata_reg >> qcol_reg;
    end

    // Item registers, clipped corners and mask
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg  <= action;
            dx_reg      <= $signed({center_x[COORD_W-1], center_x})
                           - $signed({origin_x_reg[COORD_W-1], origin_x_reg});
            dy_reg      <= $signed({origin_y_reg[COORD_W-1], origin_y_reg})
                           - $signed({center_y[COORD_W-1], center_y});
            sx_reg      <= size_x;
            sy_reg      <= size_y;
            qrow_reg    <= query_row;
            qcol_reg    <= query_col;
            blocked_reg <= 1'b0;
            oor_reg     <= 1'b0;
        end
        if (cmd.sat_load)
        begin
            lsat_reg <= (q_l > NUM_W'(MAX_COLUMNS)) ? CCW'(MAX_COLUMNS) : CCW'(q_l);
            rsat_reg <= (q_r > NUM_W'(MAX_COLUMNS)) ? CCW'(MAX_COLUMNS) : CCW'(q_r);
            usat_reg <= (q_u > NUM_W'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(q_u);
            dsat_reg <= (q_d > NUM_W'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(q_d);
        end
        if (cmd.mask_load)
            mask_reg <= mask_next;
        if (cmd.query_eval)
        begin
            oor_reg     <= q_oor;
            blocked_reg <= !q_oor && q_word[0];
        end
        if (cmd.fill_read)
            wr_addr_reg <= row_reg[RW-1:0];
    end

    // Row counter and pending OR write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= cmd.fill_read;
            if (cmd.row_zero)
                row_reg <= '0;
            else if (cmd.mask_load)
                row_reg <= usat_reg;
            else if (cmd.fill_read || cmd.clr_write)
                row_reg <= row_reg + RCW'(1);
        end
    end

    // Memory port selection
    always_comb
    begin
        wr_en   = wr_pend_reg || cmd.clr_write;
        wr_addr = cmd.clr_write ? row_reg[RW-1:0] : wr_addr_reg;
        wr_data = cmd.clr_write ? '0 : (rdata_reg | mask_reg);
        rd_en   = cmd.fill_read || cmd.query_read;
        rd_addr = cmd.query_read ? qaddr : row_reg[RW-1:0];
    end

    // Grid memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            occ_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= occ_mem[rd_addr];
    end

    // Status to the controller
    always_comb
    begin
        status.div_done   = !(run_l || run_r || run_u || run_d);
        status.mask_empty = (mask_reg == '0);
        status.row_active = (row_reg <= dsat_reg) && (row_reg < nrow);
        status.clr_last   = (row_reg == RCW'(MAX_ROWS - 1));
    end

    assign echo_action  = action_reg;
    assign blocked      = blocked_reg;
    assign out_of_range = oor_reg;

endmodule
`default_nettype wire

FILE: rtl/ogrf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy grid controller
// Sequences the reset sweep, mark, query and clear operations and raises
// the result strobe.
// ----------------------------------------------------------------------------
module ogrf_ctrl
    import ogrf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [ACT_W-1:0] action,
    input  wire ogrf_status_t     status,
    output ogrf_cmd_t             cmd,
    output logic                  busy,
    output logic                  done
);

    ogrf_state_t state_reg;
    ogrf_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            // zero every row after reset
            ST_INIT:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch = 1'b1;
                    unique case (action)
                        ACT_MARK:  state_next = ST_PREP;
                        ACT_QUERY: state_next = ST_QREAD;
                        ACT_CLEAR:
                        begin
                            cmd.row_zero = 1'b1;
                            state_next   = ST_CLR;
                        end
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_PREP:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat_load = 1'b1;
                state_next   = ST_MASK;
            end
            ST_MASK:
            begin
                cmd.mask_load = 1'b1;
                state_next    = ST_FILL;
            end
            // one row read per cycle; its OR write lands the cycle after
            ST_FILL:
            begin
                if (status.row_active && !status.mask_empty)
                    cmd.fill_read = 1'b1;
                else
                    state_next = ST_DONE;
            end
            ST_QREAD:
            begin
                cmd.query_read = 1'b1;
                state_next     = ST_QEVAL;
            end
            ST_QEVAL:
            begin
                cmd.query_eval = 1'b1;
                state_next     = ST_DONE;
            end
            ST_CLR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/occupancy_grid_rect_fill_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Occupancy grid rectangle fill unit
// Bit grid of blocked cells with rectangle mark, cell query and clear.
// ----------------------------------------------------------------------------
// Mark: the four corner divisions run together, one quotient bit a cycle, then
//   the covered rows are filled one row a cycle.
// Query: the row is read, then evaluated, then done. Clear: one row a
//   cycle through the single write port. One item at a time; busy while working.
// Reset: busy while the grid is swept to zero; config writes are taken
//   meanwhile. done is a one-cycle strobe, never held off.
module occupancy_grid_rect_fill_unit
    import ogrf_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ACT_W-1:0]      action,
    input  wire logic [COORD_W-1:0]    center_x,
    input  wire logic [COORD_W-1:0]    center_y,
    input  wire logic [SIZE_W-1:0]     size_x,
    input  wire logic [SIZE_W-1:0]     size_y,
    input  wire logic [QIDX_W-1:0]     query_row,
    input  wire logic [QIDX_W-1:0]     query_col,
    output logic                       done,
    output logic [ACT_W-1:0]           echo_action,
    output logic                       blocked,
    output logic                       out_of_range
);

    ogrf_cmd_t    cmd;
    ogrf_status_t status;

    // Sequencer
    ogrf_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Arithmetic and grid storage
    ogrf_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .center_x     (center_x),
        .center_y     (center_y),
        .size_x       (size_x),
        .size_y       (size_y),
        .query_row    (query_row),
        .query_col    (query_col),
        .cmd          (cmd),
        .status       (status),
        .echo_action  (echo_action),
        .blocked      (blocked),
        .out_of_range (out_of_range)
    );

endmodule
`default_nettype wire
